// ===== rtl/core/gad_pkg.sv =====
// Package for the 2x2 average decimator: sizes, register indexes, payload types.
// Shared by the top level, the line RAM instance and the port checker.
// Depends on nothing.
`default_nettype none

package gad_pkg;

  localparam int MaxCols   = 1024;
  localparam int MaxRows   = 1024;
  localparam int ValueW    = 32;
  localparam int LineDepth = MaxCols / 2;
  localparam int AddrW     = $clog2(LineDepth);
  localparam int PairW     = ValueW + 1;
  localparam int SumW      = ValueW + 2;
  localparam int CntW      = 10;
  localparam int CfgW      = 11;
  localparam int CfgIdxW   = 2;
  localparam int TagW      = 5;
  localparam int IdxW      = 10;

  localparam logic [CfgIdxW-1:0] REG_FINE_ROWS   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FINE_COLS   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_COARSE_ROWS = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_COARSE_COLS = 2'd3;

  localparam logic [CfgW-1:0] CfgResetVal = CfgW'(1);
  localparam logic [CfgW-1:0] MaxRowsCfg  = CfgW'(MaxRows);
  localparam logic [CfgW-1:0] MaxColsCfg  = CfgW'(MaxCols);

  typedef struct packed {
    logic signed [ValueW-1:0] sample;
    logic [TagW-1:0]          plane_tag;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueW-1:0] average;
    logic [TagW-1:0]          plane_out;
    logic [IdxW-1:0]          coarse_row;
    logic [IdxW-1:0]          coarse_col;
  } out_item_t;

  // Position of an item in the block, worked out when it is accepted.
  typedef struct packed {
    logic             odd_col;
    logic             odd_row;
    logic             last_col;
    logic             last_row;
    logic [AddrW-1:0] slot;
    logic [IdxW-1:0]  crow;
    logic [IdxW-1:0]  ccol;
  } pos_t;

  // A size of zero counts as one, and a size above the maximum as the maximum.
  function automatic logic [CfgW-1:0] clamp_size(logic [CfgW-1:0] v, logic [CfgW-1:0] lim);
    logic [CfgW-1:0] r;
    if (v == '0) begin
      r = CfgW'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Coarse index limited to size minus one, with a size of zero taken as one.
  function automatic logic [IdxW-1:0] clamp_index(logic [CntW-2:0] half, logic [CfgW-1:0] size);
    logic [CfgW-1:0] lim;
    logic [CfgW-1:0] wide;
    logic [IdxW-1:0] r;
    lim  = (size == '0) ? '0 : size - CfgW'(1);
    wide = {{(CfgW-CntW+1){1'b0}}, half};
    if (wide > lim) begin
      r = lim[IdxW-1:0];
    end else begin
      r = wide[IdxW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gad_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Read data holds while no read is enabled. Depends on nothing.
`default_nettype none

module gad_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/grid_2x2_average_decimator.sv =====
// Path: an accepted transaction is registered in stage one; when it completes its block, the
// result register loads from stage one, and the result is held there until it is taken.
// Throughput: one input transaction per cycle; the line RAM has one write and one read port.
// The input stalls only while the output register holds an untaken result and the
// item behind it also completes a block.
// Reset clears counters, the held sample and valid flags; configuration registers reset to one.
// The line RAM is not cleared; every entry is written before its read data is used.
`default_nettype none

module grid_2x2_average_decimator
  import gad_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire in_item_t           in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_item_t               out_item_o
);

  logic [CfgW-1:0] fine_rows_q, fine_cols_q, coarse_rows_q, coarse_cols_q;
  logic [CntW-1:0] row_q, row_d, col_q, col_d;
  logic signed [ValueW-1:0] held_q;

  logic      s1_valid_q, s1_valid_d;
  pos_t      s1_pos_q, pos_d;
  in_item_t  s1_item_q;
  logic      fwd_q;
  logic [PairW-1:0] fwd_data_q;

  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  logic            accept;
  logic [CfgW-1:0] rows_eff, cols_eff, row_inc, col_inc;
  logic            last_row, last_col;

  logic signed [PairW-1:0] pair, line_val;
  logic signed [SumW-1:0]  total;
  logic [PairW-1:0]        ram_rd_data;
  logic                    have_pair, emit, s1_move, wr_en;

  // Configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fine_rows_q   <= CfgResetVal;
      fine_cols_q   <= CfgResetVal;
      coarse_rows_q <= CfgResetVal;
      coarse_cols_q <= CfgResetVal;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FINE_ROWS:   fine_rows_q   <= cfg_data_i;
        REG_FINE_COLS:   fine_cols_q   <= cfg_data_i;
        REG_COARSE_ROWS: coarse_rows_q <= cfg_data_i;
        REG_COARSE_COLS: coarse_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: position of the incoming sample and raster counters.
  always_comb begin
    rows_eff = clamp_size(fine_rows_q, MaxRowsCfg);
    cols_eff = clamp_size(fine_cols_q, MaxColsCfg);
    row_inc  = {1'b0, row_q} + CfgW'(1);
    col_inc  = {1'b0, col_q} + CfgW'(1);
    last_row = row_inc >= rows_eff;
    last_col = col_inc >= cols_eff;

    pos_d.odd_col  = col_q[0];
    pos_d.odd_row  = row_q[0];
    pos_d.last_col = last_col;
    pos_d.last_row = last_row;
    pos_d.slot     = col_q[CntW-1:1];
    pos_d.crow     = clamp_index(row_q[CntW-1:1], coarse_rows_q);
    pos_d.ccol     = clamp_index(col_q[CntW-1:1], coarse_cols_q);

    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_inc[CntW-1:0];
    end else begin
      col_d = col_inc[CntW-1:0];
      row_d = row_q;
    end
  end

  assign accept = in_valid_i && !in_stall_o;

  // Stage one: pair sum, line lookup and block total.
  always_comb begin
    have_pair = s1_pos_q.odd_col || s1_pos_q.last_col;
    if (s1_pos_q.odd_col) begin
      pair = PairW'(held_q) + PairW'(s1_item_q.sample);
    end else begin
      pair = PairW'(s1_item_q.sample) + PairW'(s1_item_q.sample);
    end
    line_val = fwd_q ? fwd_data_q : ram_rd_data;
    if (s1_pos_q.odd_row) begin
      total = SumW'(line_val) + SumW'(pair);
    end else begin
      total = SumW'(pair) + SumW'(pair);
    end
    emit    = have_pair && (s1_pos_q.odd_row || s1_pos_q.last_row);
    wr_en   = s1_valid_q && have_pair && !s1_pos_q.odd_row && !s1_pos_q.last_row;
    s1_move = !s1_valid_q || !emit || !out_valid_q || !out_stall_i;

    out_item_d.average    = total[SumW-1:2];
    out_item_d.plane_out  = s1_item_q.plane_tag;
    out_item_d.coarse_row = s1_pos_q.crow;
    out_item_d.coarse_col = s1_pos_q.ccol;

    s1_valid_d  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_q);
    out_valid_d = (s1_valid_q && emit && s1_move) ? 1'b1 : (out_valid_q && out_stall_i);
  end

  assign in_stall_o = !s1_move;

  gad_ram #(
    .Width(PairW),
    .Depth(LineDepth)
  ) u_line (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_pos_q.slot),
    .wr_data_i (pair),
    .rd_en_i   (accept),
    .rd_addr_i (pos_d.slot),
    .rd_data_o (ram_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      held_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        row_q <= row_d;
        col_q <= col_d;
        // A write leaving stage one at this edge is not yet visible in the RAM read.
        fwd_q <= wr_en && (s1_pos_q.slot == pos_d.slot);
      end
      if (s1_valid_q && !s1_pos_q.odd_col && !s1_pos_q.last_col) begin
        held_q <= s1_item_q.sample;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q  <= in_item_i;
      s1_pos_q   <= pos_d;
      fwd_data_q <= pair;
    end
    if (s1_valid_q && emit && s1_move) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ===== rtl/core/gad_checker.sv =====
// Port-level checker for the 2x2 average decimator, bound to the top level.
// Depends on gad_pkg for the payload types.
`default_nettype none

module gad_checker
  import gad_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_item_o
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output changed");

  // Once reset has been seen asserted, no result is shown at the next edge.
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  // A fresh result follows an input transaction that passed through stage one into the result register.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without matching input");

  // The input side only stalls when the output register is full and stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

endmodule

bind grid_2x2_average_decimator gad_checker u_gad_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
